// ===== rtl/gfns_pkg.sv =====
package gfns_pkg;

  // input word: one load or emit command
  typedef struct packed {
    logic       action;
    logic [7:0] gray_value;
  } in_word_t;

  // result word: one display pixel
  typedef struct packed {
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic [15:0] color;
    logic        frame_end;
  } out_word_t;

  // command codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE   = 2'd2;

  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned POS_W      = 10;

  // gray to rgb565 by truncation, blue equals red
  function automatic logic [15:0] gray_to_rgb565(input logic [7:0] g);
    return {g[7:3], g[7:2], g[7:3]};
  endfunction

endpackage

// ===== rtl/gfns_ram.sv =====
module gfns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 14400
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/gray_frame_nearest_scaler_rgb565_core.sv =====
// an emit word accepted in one cycle shows its pixel on out_valid the next cycle
// throughput: one word per clock, loads and emits alike; busy never rises
// the frame store is one single-port-write, registered-read ram; a load and an emit
// never share a cycle, so the one write port and one read port suffice
// reset (rst_n low, synchronous) clears load address, raster position, offsets and out_valid and sets rotate;
// frame store contents stay undefined until loaded; the receiver cannot stall
module gray_frame_nearest_scaler_rgb565_core #(
  parameter int unsigned SRC_WIDTH  = 160,
  parameter int unsigned SRC_HEIGHT = 90,
  parameter int unsigned DST_WIDTH  = 240,
  parameter int unsigned DST_HEIGHT = 135
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  gfns_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  output gfns_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [gfns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gfns_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (DST_WIDTH  > 1) ? $clog2(DST_WIDTH)  : 1;
  localparam int unsigned RW    = (DST_HEIGHT > 1) ? $clog2(DST_HEIGHT) : 1;
  // remainders stay below twice the display size
  localparam int unsigned XRW   = $clog2(DST_WIDTH)  + 1;
  localparam int unsigned YRW   = $clog2(DST_HEIGHT) + 1;
  // per-step source advance: quotient and remainder of src over dst
  localparam int unsigned QX    = SRC_WIDTH  / DST_WIDTH;
  localparam int unsigned RX    = SRC_WIDTH  % DST_WIDTH;
  localparam int unsigned QY    = SRC_HEIGHT / DST_HEIGHT;
  localparam int unsigned RY    = SRC_HEIGHT % DST_HEIGHT;
  localparam int unsigned YSTEP = QY * SRC_WIDTH;

  // command accept
  logic accept;
  logic do_load;
  logic do_emit;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign do_load = accept && (in_data.action == gfns_pkg::ACT_LOAD);
  assign do_emit = accept && (in_data.action == gfns_pkg::ACT_EMIT);

  // configuration registers
  logic [8:0] offset_x_r;
  logic [8:0] offset_y_r;
  logic       rotate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      rotate_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfns_pkg::CFG_OFFSET_X: offset_x_r <= cfg_wdata[8:0];
        gfns_pkg::CFG_OFFSET_Y: offset_y_r <= cfg_wdata[8:0];
        gfns_pkg::CFG_ROTATE:   rotate_r   <= cfg_wdata[0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // load address, raster order with wrap
  logic [AW-1:0] load_addr_r;
  logic [AW-1:0] load_addr_nxt;

  always_comb begin
    load_addr_nxt = load_addr_r;
    if (do_load) begin
      if (load_addr_r == AW'(DEPTH - 1)) begin
        load_addr_nxt = '0;
      end else begin
        load_addr_nxt = load_addr_r + AW'(1);
      end
    end
  end

  // display raster position and incremental source coordinate
  // sx tracks floor(col*SRC_WIDTH/DST_WIDTH) via quotient plus remainder carry
  // ybase tracks floor(row*SRC_HEIGHT/DST_HEIGHT)*SRC_WIDTH the same way
  logic [CW-1:0]  col_r,   col_nxt;
  logic [RW-1:0]  row_r,   row_nxt;
  logic [AW-1:0]  sx_r,    sx_nxt;
  logic [XRW-1:0] xrem_r,  xrem_nxt;
  logic [AW-1:0]  ybase_r, ybase_nxt;
  logic [YRW-1:0] yrem_r,  yrem_nxt;

  logic           col_last;
  logic           row_last;
  logic [XRW-1:0] xrem_sum;
  logic [YRW-1:0] yrem_sum;

  assign col_last = (col_r == CW'(DST_WIDTH - 1));
  assign row_last = (row_r == RW'(DST_HEIGHT - 1));
  assign xrem_sum = xrem_r + XRW'(RX);
  assign yrem_sum = yrem_r + YRW'(RY);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    sx_nxt    = sx_r;
    xrem_nxt  = xrem_r;
    ybase_nxt = ybase_r;
    yrem_nxt  = yrem_r;
    if (do_emit) begin
      if (col_last) begin
        col_nxt  = '0;
        sx_nxt   = '0;
        xrem_nxt = '0;
        if (row_last) begin
          // frame wrap
          row_nxt   = '0;
          ybase_nxt = '0;
          yrem_nxt  = '0;
        end else begin
          row_nxt = row_r + RW'(1);
          if (yrem_sum >= YRW'(DST_HEIGHT)) begin
            yrem_nxt  = yrem_sum - YRW'(DST_HEIGHT);
            ybase_nxt = ybase_r + AW'(YSTEP) + AW'(SRC_WIDTH);
          end else begin
            yrem_nxt  = yrem_sum;
            ybase_nxt = ybase_r + AW'(YSTEP);
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (xrem_sum >= XRW'(DST_WIDTH)) begin
          xrem_nxt = xrem_sum - XRW'(DST_WIDTH);
          sx_nxt   = sx_r + AW'(QX) + AW'(1);
        end else begin
          xrem_nxt = xrem_sum;
          sx_nxt   = sx_r + AW'(QX);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
      sx_r        <= '0;
      xrem_r      <= '0;
      ybase_r     <= '0;
      yrem_r      <= '0;
    end else begin
      load_addr_r <= load_addr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sx_r        <= sx_nxt;
      xrem_r      <= xrem_nxt;
      ybase_r     <= ybase_nxt;
      yrem_r      <= yrem_nxt;
    end
  end

  // store address: linear index, mirrored in both axes is depth-1 minus it
  logic [AW-1:0] lin_addr;
  logic [AW-1:0] rd_addr;

  assign lin_addr = ybase_r + sx_r;
  assign rd_addr  = rotate_r ? (AW'(DEPTH - 1) - lin_addr) : lin_addr;

  logic [7:0] pix;

  gfns_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (load_addr_r),
    .wr_data (in_data.gray_value),
    .rd_addr (rd_addr),
    .rd_data (pix)
  );

  // output stage, aligned with the ram read register
  logic                       out_valid_r;
  logic [gfns_pkg::POS_W-1:0] scr_x_r;
  logic [gfns_pkg::POS_W-1:0] scr_y_r;
  logic                       frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= do_emit;
    end
  end

  // payload, no reset needed; offset sum wraps modulo 1024
  always_ff @(posedge clk) begin
    if (do_emit) begin
      scr_x_r     <= gfns_pkg::POS_W'(offset_x_r) + gfns_pkg::POS_W'(col_r);
      scr_y_r     <= gfns_pkg::POS_W'(offset_y_r) + gfns_pkg::POS_W'(row_r);
      frame_end_r <= col_last && row_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.screen_x  = scr_x_r;
  assign out_data.screen_y  = scr_y_r;
  assign out_data.color     = gfns_pkg::gray_to_rgb565(pix);
  assign out_data.frame_end = frame_end_r;

endmodule
